// ===== hw/rtl/bgas_pkg.sv =====
// Package: shared types and constants of the binary grid smoother.
`timescale 1ns / 1ps

package bgas_pkg;

  // Grid store geometry
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned ROW_AW   = $clog2(MAX_ROWS);
  localparam int unsigned CNT_W    = 7;

  // Item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_GRID_ROWS   = 3'd0;
  localparam logic [2:0] CFG_GRID_COLS   = 3'd1;
  localparam logic [2:0] CFG_GENERATIONS = 3'd2;
  localparam logic [2:0] CFG_SURVIVE_MIN = 3'd3;
  localparam logic [2:0] CFG_BIRTH_MIN   = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row_index;
    logic [5:0] col_index;
    logic       cell_in;
  } in_t;

  typedef struct packed {
    logic cell_out;
    logic done_flag;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_OP,
    ST_GEN_RD,
    ST_GEN_SH,
    ST_GEN_WR,
    ST_RESP
  } state_e;

endpackage

// ===== hw/rtl/binary_grid_automaton_smoother_top.sv =====
// Top level: binary cell grid with cell access and iterative smoothing sweeps.
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Beat
// -------   ---  ---------------------  -----------------------------------
// in        in   in_valid_i/in_stall_o   kind, row_index, col_index, cell_in
// out       out  out_valid_o/out_stall_i cell_out, done_flag
// cfg       in   cfg_valid_i/cfg_ready_o register index, write data
//
// A write or read beat inside the grid passes through a read of the row
// store, a modify or extract step and the load of the result; the next beat
// is taken once the block is back in idle.
// A beat outside the grid, the unused kind and a run with no generations go
// straight to the load.
// A run beat sweeps the active rows once per generation: each row step is a
// read, a window shift and an update through the single row unit, paced by
// the one read port of the row store. Its result is loaded after the last
// generation.
// Reset clears the configuration to its defaults and marks every row invalid;
// an invalid row reads as all empty, so no clearing pass is needed.
// The result sits in an output register; a stalled result holds and the
// block still accepts the next beat, whose load step waits until the held
// result has left, adding the remaining stall cycles.

module binary_grid_automaton_smoother_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bgas_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bgas_pkg::out_t      out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [6:0]          cfg_data_i
);

  localparam int unsigned NC = bgas_pkg::MAX_COLS;

  // Configuration
  logic [bgas_pkg::CNT_W-1:0] rows_q, cols_q;
  logic [3:0]                 gens_q, surv_q, birth_q;
  logic [bgas_pkg::CNT_W-1:0] rows_eff, cols_eff;

  // Control
  bgas_pkg::state_e           state_q, state_d;
  bgas_pkg::in_t              item_q;
  logic [bgas_pkg::CNT_W-1:0] ld_q;
  logic [3:0]                 gen_q;
  logic                       out_valid_q;
  bgas_pkg::out_t             out_q;
  logic                       cell_q;
  logic [bgas_pkg::MAX_ROWS-1:0] row_vld_q;

  // Row store and window
  logic [NC-1:0]              mem [bgas_pkg::MAX_ROWS];
  logic [NC-1:0]              rd_data_q;
  logic                       rd_vld_q;
  logic [NC-1:0]              w0_q, w1_q, w2_q;

  // Combinational controls
  logic                       in_acc, out_free, item_inside;
  logic                       sweep_end, last_gen;
  logic                       mem_we;
  logic [bgas_pkg::ROW_AW-1:0] rd_addr, wr_addr;
  logic [NC-1:0]              wr_data, row_eff, row_mod, col_mask, upd_row, sweep_row;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rows_eff = (rows_q > bgas_pkg::CNT_W'(bgas_pkg::MAX_ROWS)) ?
                    bgas_pkg::CNT_W'(bgas_pkg::MAX_ROWS) : rows_q;
  assign cols_eff = (cols_q > bgas_pkg::CNT_W'(NC)) ? bgas_pkg::CNT_W'(NC) : cols_q;

  assign item_inside = ({1'b0, in_data_i.row_index} < rows_eff) &&
                       ({1'b0, in_data_i.col_index} < cols_eff);
  assign sweep_end   = (ld_q == rows_eff);
  assign last_gen    = (4'(gen_q + 4'd1) == gens_q);

  // A never-written row reads as empty
  assign row_eff = rd_vld_q ? rd_data_q : '0;

  // Cell write: replace one bit of the fetched row
  always_comb begin
    row_mod = row_eff & ~(NC'(1) << item_q.col_index);
    row_mod = row_mod | (NC'(item_q.cell_in) << item_q.col_index);
  end

  // Row fed into the window: zero beyond the last active row
  assign sweep_row = (ld_q < rows_eff) ? row_eff : '0;

  // Active column mask
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      col_mask[c] = (bgas_pkg::CNT_W'(c) < cols_eff);
    end
  end

  // Shared row unit: update all lanes of the middle window row
  always_comb begin
    logic [NC+1:0] pa, pb, pc;
    logic [3:0]    n;
    pa = {1'b0, w0_q & col_mask, 1'b0};
    pb = {1'b0, w1_q & col_mask, 1'b0};
    pc = {1'b0, w2_q & col_mask, 1'b0};
    upd_row = '0;
    for (int c = 0; c < NC; c++) begin
      n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2]) +
          4'(pb[c]) + 4'(pb[c+2]) +
          4'(pc[c]) + 4'(pc[c+1]) + 4'(pc[c+2]);
      upd_row[c] = pb[c+1] ? (n >= surv_q) : (n >= birth_q);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bgas_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (in_data_i.kind == bgas_pkg::KIND_RUN) begin
            state_d = (gens_q == 4'd0) ? bgas_pkg::ST_RESP : bgas_pkg::ST_GEN_RD;
          end else if ((in_data_i.kind == bgas_pkg::KIND_WRITE ||
                        in_data_i.kind == bgas_pkg::KIND_READ) && item_inside) begin
            state_d = bgas_pkg::ST_CELL_RD;
          end else begin
            state_d = bgas_pkg::ST_RESP;
          end
        end
      end
      bgas_pkg::ST_CELL_RD: state_d = bgas_pkg::ST_CELL_OP;
      bgas_pkg::ST_CELL_OP: state_d = bgas_pkg::ST_RESP;
      bgas_pkg::ST_GEN_RD:  state_d = bgas_pkg::ST_GEN_SH;
      bgas_pkg::ST_GEN_SH:  state_d = bgas_pkg::ST_GEN_WR;
      bgas_pkg::ST_GEN_WR: begin
        state_d = (sweep_end && last_gen) ? bgas_pkg::ST_RESP : bgas_pkg::ST_GEN_RD;
      end
      bgas_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = bgas_pkg::ST_IDLE;
        end
      end
      default: state_d = bgas_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    rd_addr    = ld_q[bgas_pkg::ROW_AW-1:0];
    wr_addr    = item_q.row_index;
    wr_data    = row_mod;
    unique case (state_q)
      bgas_pkg::ST_IDLE:    in_stall_o = 1'b0;
      bgas_pkg::ST_CELL_RD: rd_addr = item_q.row_index;
      bgas_pkg::ST_CELL_OP: mem_we = (item_q.kind == bgas_pkg::KIND_WRITE);
      bgas_pkg::ST_GEN_WR: begin
        mem_we  = (ld_q != '0);
        wr_addr = bgas_pkg::ROW_AW'(ld_q - bgas_pkg::CNT_W'(1));
        wr_data = (w1_q & ~col_mask) | (upd_row & col_mask);
      end
      default: ;
    endcase
  end

  // Row store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= row_vld_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (mem_we) begin
      row_vld_q[wr_addr] <= 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= bgas_pkg::CNT_W'(64);
      cols_q  <= bgas_pkg::CNT_W'(64);
      gens_q  <= 4'd5;
      surv_q  <= 4'd4;
      birth_q <= 4'd5;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bgas_pkg::CFG_GRID_ROWS:   rows_q  <= cfg_data_i;
        bgas_pkg::CFG_GRID_COLS:   cols_q  <= cfg_data_i;
        bgas_pkg::CFG_GENERATIONS: gens_q  <= cfg_data_i[3:0];
        bgas_pkg::CFG_SURVIVE_MIN: surv_q  <= cfg_data_i[3:0];
        bgas_pkg::CFG_BIRTH_MIN:   birth_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgas_pkg::ST_IDLE;
      ld_q        <= '0;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        ld_q  <= '0;
        gen_q <= '0;
      end else if (state_q == bgas_pkg::ST_GEN_WR) begin
        if (sweep_end) begin
          ld_q  <= '0;
          gen_q <= 4'(gen_q + 4'd1);
        end else begin
          ld_q <= bgas_pkg::CNT_W'(ld_q + bgas_pkg::CNT_W'(1));
        end
      end
      if (state_q == bgas_pkg::ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, window and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
      cell_q <= 1'b0;
    end
    if (state_q == bgas_pkg::ST_CELL_OP) begin
      cell_q <= row_eff[item_q.col_index];
    end
    // Clear the window at the start of every sweep
    if (in_acc || (state_q == bgas_pkg::ST_GEN_WR && sweep_end)) begin
      w0_q <= '0;
      w1_q <= '0;
      w2_q <= '0;
    end else if (state_q == bgas_pkg::ST_GEN_SH) begin
      w0_q <= w1_q;
      w1_q <= w2_q;
      w2_q <= sweep_row;
    end
    if (state_q == bgas_pkg::ST_RESP && out_free) begin
      out_q.cell_out  <= (item_q.kind == bgas_pkg::KIND_READ) && cell_q;
      out_q.done_flag <= (item_q.kind == bgas_pkg::KIND_RUN);
    end
  end

  // Checks
  a_store_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == bgas_pkg::ST_CELL_OP || state_q == bgas_pkg::ST_GEN_WR))
    else $error("row store written outside a write step");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgas_pkg::ST_GEN_WR) |-> (ld_q <= rows_eff))
    else $error("sweep row counter ran past the active rows");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == bgas_pkg::ST_RESP))
    else $error("result raised outside the response step");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.cell_out && out_q.done_flag))
    else $error("result carries both a cell and a done flag");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != bgas_pkg::ST_IDLE))
    else $error("sequencer idle right after taking a beat");

endmodule

// ===== dv/bgas_grid_checker.sv =====
// Checker: shadow grid predictor and in-order result comparison for the grid smoother.
`timescale 1ns / 1ps

module bgas_grid_checker
  import bgas_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_t        in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_t       out_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [2:0] cfg_index_i,
  input  logic [6:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  logic [63:0] shadow_grid [MAX_ROWS];
  logic [6:0]  cfg_rows;
  logic [6:0]  cfg_cols;
  logic [3:0]  cfg_gens;
  logic [3:0]  cfg_survive;
  logic [3:0]  cfg_birth;

  out_t due_results [$];
  out_t want;
  int   fails;

  function automatic int active_rows();
    return (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
  endfunction

  function automatic int active_cols();
    return (cfg_cols > MAX_COLS) ? MAX_COLS : int'(cfg_cols);
  endfunction

  // Cells beyond the active edges count as empty.
  function automatic int neighbour_count(int r, int c, int nr, int nc);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (!(dr == 0 && dc == 0) && r + dr >= 0 && r + dr < nr &&
            c + dc >= 0 && c + dc < nc) begin
          n += shadow_grid[r + dr][c + dc];
        end
      end
    end
    return n;
  endfunction

  // One generation; every cell reads the old grid, cells outside are kept.
  function automatic void smooth_once();
    int nr;
    int nc;
    int n;
    logic [63:0] nxt [MAX_ROWS];
    nr = active_rows();
    nc = active_cols();
    for (int r = 0; r < MAX_ROWS; r++) nxt[r] = shadow_grid[r];
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        n = neighbour_count(r, c, nr, nc);
        if (shadow_grid[r][c]) begin
          if (n < int'(cfg_survive)) nxt[r][c] = 1'b0;
        end else if (n >= int'(cfg_birth)) begin
          nxt[r][c] = 1'b1;
        end
      end
    end
    for (int r = 0; r < MAX_ROWS; r++) shadow_grid[r] = nxt[r];
  endfunction

  function automatic out_t predict_beat(in_t beat);
    out_t res;
    logic in_grid;
    res = '0;
    in_grid = (int'(beat.row_index) < active_rows()) &&
              (int'(beat.col_index) < active_cols());
    case (beat.kind)
      KIND_WRITE: begin
        if (in_grid) shadow_grid[beat.row_index][beat.col_index] = beat.cell_in;
      end
      KIND_RUN: begin
        repeat (cfg_gens) smooth_once();
        res.done_flag = 1'b1;
      end
      KIND_READ: begin
        if (in_grid) res.cell_out = shadow_grid[beat.row_index][beat.col_index];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_ROWS; r++) shadow_grid[r] = '0;
      cfg_rows    = 7'd64;
      cfg_cols    = 7'd64;
      cfg_gens    = 4'd5;
      cfg_survive = 4'd4;
      cfg_birth   = 4'd5;
      due_results.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Compare first: a result never belongs to a beat taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with no beat outstanding, cell_out %0b done_flag %0b",
                   $time, out_data_i.cell_out, out_data_i.done_flag);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (out_data_i.cell_out !== want.cell_out) begin
            $display("%0t: cell_out mismatch, expected %0b, actual %0b",
                     $time, want.cell_out, out_data_i.cell_out);
            fails++;
          end
          if (out_data_i.done_flag !== want.done_flag) begin
            $display("%0t: done_flag mismatch, expected %0b, actual %0b",
                     $time, want.done_flag, out_data_i.done_flag);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_GRID_ROWS:   cfg_rows    = cfg_data_i;
          CFG_GRID_COLS:   cfg_cols    = cfg_data_i;
          CFG_GENERATIONS: cfg_gens    = cfg_data_i[3:0];
          CFG_SURVIVE_MIN: cfg_survive = cfg_data_i[3:0];
          CFG_BIRTH_MIN:   cfg_birth   = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) due_results.push_back(predict_beat(in_data_i));
      fail_count_o <= fails;
      pending_o    <= due_results.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top: stimulus, handshake pacing and verdict for the grid smoother.
`timescale 1ns / 1ps

module tb;
  import bgas_pkg::*;

  // Kind 3 has no meaning in the block; it must leave the grid alone.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [6:0] cfg_data;

  int fail_count;
  int pending;

  // Idle percentages of the current phase, per side.
  int gap_pct   = 0;
  int stall_pct = 0;

  // Active settings, kept here only to aim the random cell addresses.
  int set_rows;
  int set_cols;

  always #5 clk_i = ~clk_i;

  binary_grid_automaton_smoother_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  bgas_grid_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver back-pressure: a fresh coin every cycle at the phase's rate.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic in_t cell_beat(logic [1:0] k, int r, int c, logic v);
    in_t b;
    b.kind      = k;
    b.row_index = r[5:0];
    b.col_index = c[5:0];
    b.cell_in   = v;
    return b;
  endfunction

  // Mostly addresses inside the active grid so that writes shape what the
  // runs smooth; a share of full-range addresses probes the outside cases.
  function automatic in_t random_beat();
    in_t b;
    int  sel;
    int  nr;
    int  nc;
    nr  = (set_rows > MAX_ROWS) ? MAX_ROWS : set_rows;
    nc  = (set_cols > MAX_COLS) ? MAX_COLS : set_cols;
    sel = $urandom_range(0, 99);
    if (sel < 40)      b.kind = KIND_WRITE;
    else if (sel < 48) b.kind = KIND_RUN;
    else if (sel < 95) b.kind = KIND_READ;
    else               b.kind = KIND_UNUSED;
    if (nr == 0 || $urandom_range(0, 99) < 12) b.row_index = 6'($urandom_range(0, 63));
    else                                       b.row_index = 6'($urandom_range(0, nr - 1));
    if (nc == 0 || $urandom_range(0, 99) < 12) b.col_index = 6'($urandom_range(0, 63));
    else                                       b.col_index = 6'($urandom_range(0, nc - 1));
    b.cell_in = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // Offer one beat, after any sender gap, and hold it until taken.
  task automatic send_beat(input in_t beat);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[6:0];
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Write all five registers with the block idle; valid drops only at the end
  // so that it is never lowered and raised within one step.
  task automatic load_settings(input int rows, input int cols, input int gens,
                               input int survive, input int birth);
    wait_drained();
    write_reg(CFG_GRID_ROWS,   rows);
    write_reg(CFG_GRID_COLS,   cols);
    write_reg(CFG_GENERATIONS, gens);
    write_reg(CFG_SURVIVE_MIN, survive);
    write_reg(CFG_BIRTH_MIN,   birth);
    cfg_valid <= 1'b0;
    set_rows = rows;
    set_cols = cols;
  endtask

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int rows;
    int cols;
    int gens;
    int survive;
    int birth;

    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_GRID_ROWS;
    cfg_data  <= '0;
    set_rows  = 64;
    set_cols  = 64;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, default settings: corner cells, overwrite, read of a cell
    // never written, the unused kind with every field bit set, and a small
    // block that the default thresholds erode.
    send_beat(cell_beat(KIND_WRITE, 0, 0, 1'b1));
    send_beat(cell_beat(KIND_WRITE, 63, 63, 1'b1));
    send_beat(cell_beat(KIND_WRITE, 0, 63, 1'b1));
    send_beat(cell_beat(KIND_WRITE, 63, 0, 1'b1));
    send_beat(cell_beat(KIND_READ, 0, 0, 1'b0));
    send_beat(cell_beat(KIND_READ, 63, 63, 1'b0));
    send_beat(cell_beat(KIND_WRITE, 63, 63, 1'b0));
    send_beat(cell_beat(KIND_READ, 63, 63, 1'b1));
    send_beat(cell_beat(KIND_READ, 5, 5, 1'b0));
    send_beat(cell_beat(KIND_UNUSED, 63, 63, 1'b1));
    send_beat(cell_beat(KIND_READ, 63, 0, 1'b0));
    send_beat(cell_beat(KIND_WRITE, 10, 20, 1'b1));
    send_beat(cell_beat(KIND_WRITE, 10, 21, 1'b1));
    send_beat(cell_beat(KIND_WRITE, 11, 20, 1'b1));
    send_beat(cell_beat(KIND_WRITE, 11, 21, 1'b1));
    send_beat(cell_beat(KIND_RUN, 0, 0, 1'b0));
    send_beat(cell_beat(KIND_READ, 10, 20, 1'b0));

    // Small grid, no generations: writes and reads beyond the edges are
    // ignored and read as empty, stored cells out there survive the run.
    load_settings(3, 5, 0, 0, 9);
    send_beat(cell_beat(KIND_WRITE, 4, 2, 1'b1));
    send_beat(cell_beat(KIND_READ, 63, 0, 1'b0));
    send_beat(cell_beat(KIND_RUN, 0, 0, 1'b0));
    send_beat(cell_beat(KIND_READ, 0, 63, 1'b0));

    // Empty grid with thresholds above the neighbour count: still done.
    load_settings(0, 64, 15, 15, 9);
    send_beat(cell_beat(KIND_RUN, 0, 0, 1'b0));
    send_beat(cell_beat(KIND_READ, 0, 0, 1'b0));

    // Oversized register values clamp to the store; every live cell dies and
    // every dead cell is born, over the longest run.
    load_settings(127, 127, 15, 9, 0);
    send_beat(cell_beat(KIND_WRITE, 63, 63, 1'b1));
    send_beat(cell_beat(KIND_RUN, 0, 0, 1'b0));
    send_beat(cell_beat(KIND_READ, 63, 63, 1'b0));

    // Random phases: rotate the idling pattern and the settings. Keep most
    // grids small so that runs stay short.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          rows = 64; cols = 64; gens = 2; survive = 4; birth = 5;
        end
        1: begin
          rows = 127; cols = 100; gens = 1; survive = 3; birth = 6;
        end
        default: begin
          rows = $urandom_range(1, 16);
          cols = $urandom_range(1, 64);
          gens = $urandom_range(0, 15);
          survive = ($urandom_range(0, 99) < 75) ? $urandom_range(3, 5)
                                                 : $urandom_range(0, 15);
          birth   = ($urandom_range(0, 99) < 75) ? $urandom_range(4, 6)
                                                 : $urandom_range(0, 15);
        end
      endcase
      load_settings(rows, cols, gens, survive, birth);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 47; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 47; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      repeat (80) send_beat(random_beat());
    end

    // Drain, then wait for any stray result to show up.
    wait_drained();
    repeat (12) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bgas_pkg.sv
hw/rtl/binary_grid_automaton_smoother_top.sv
dv/bgas_grid_checker.sv
dv/tb.sv
